>>> sv/bpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpd_pkg;

    // Default number of entries the list can hold.
    localparam int BPD_CAPACITY = 256;

    // Field widths of one request and one result.
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = 3 * BYTE_W;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 9;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_RM_HEAD  = 3'd2;
    localparam logic [OP_W-1:0] OP_RM_TAIL  = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_HEAD  = 3'd4;
    localparam logic [OP_W-1:0] OP_RD_TAIL  = 3'd5;
    localparam logic [OP_W-1:0] OP_RD_INDEX = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Memory address selection codes.
    localparam int ASEL_W = 3;
    localparam logic [ASEL_W-1:0] ASEL_HEAD      = 3'd0;
    localparam logic [ASEL_W-1:0] ASEL_HEAD_PREV = 3'd1;
    localparam logic [ASEL_W-1:0] ASEL_TAIL_NEW  = 3'd2;
    localparam logic [ASEL_W-1:0] ASEL_TAIL      = 3'd3;
    localparam logic [ASEL_W-1:0] ASEL_INDEX     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                exec;
        logic                wr_en;
        logic [ASEL_W-1:0]   addr_sel;
        logic                head_inc;
        logic                head_dec;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                rd_hit;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            pos_oob;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/bounded_position_deque.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque of position entries (symbol, x, y) held in a circular buffer.
// Requests enter on the s_axis channel; each carries an operation (insert or
// remove at the head or tail, read head, read tail, read by position) plus the
// entry fields and a position. Every request yields exactly one result on the
// m_axis channel with a status, the entry read (zeros unless a read
// succeeded) and the occupancy after the operation.
// Full inserts, removes or reads on an empty list, and positions past the
// tail leave the list unchanged and are flagged in the status.
// Timing: a request is taken when s_axis_tready is high, which is the case
// whenever no request is in progress. The request is captured, the
// single-port entry memory is accessed once, and the registered result is
// then held valid until m_axis_tready takes it; while the receiver stalls, no
// new request is taken. The next request can be accepted in the cycle after
// the result is taken, so a new request is never taken before the last one
// is through.
// Reset (synchronous, active low) empties the list and sets the head to slot
// zero; memory contents are not cleared and need no clearing pass.

module bounded_position_deque
    import bpd_pkg::*;
#(
    parameter int CAPACITY = BPD_CAPACITY
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[2:0], entry_symbol[10:3], entry_x[18:11], entry_y[26:19],
    // position[34:27], zero padding[39:35]
    input  wire  [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    // status[1:0], out_symbol[9:2], out_x[17:10], out_y[25:18],
    // occupancy[34:26], zero padding[39:35]
    output logic [OUT_W-1:0]  m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;

    // Request sequencing and operation decode.
    bpd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // Pointers, count, entry memory and result registers.
    bpd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .o_m_tdata (m_axis_tdata),
        .i_cmd     (cmd),
        .o_stat    (stat)
    );

endmodule

`default_nettype wire

>>> sv/bpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpd_ctrl
    import bpd_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_valid,
    output logic  o_s_ready,
    output logic  o_m_valid,
    input  wire   i_m_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Sequencer: take a request, run it against the store, hold the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_OUT);

    // Operation decode, qualified by the list's full, empty and range flags.
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ASEL_HEAD;
        o_cmd.status   = ST_OK;
        o_cmd.load     = (r_state == S_IDLE) && i_s_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        if (r_state == S_EXEC) begin
            unique case (i_stat.op)
                OP_INS_HEAD: begin
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.addr_sel = ASEL_HEAD_PREV;
                        o_cmd.head_dec = 1'b1;
                        o_cmd.cnt_inc  = 1'b1;
                    end
                end
                OP_INS_TAIL: begin
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.addr_sel = ASEL_TAIL_NEW;
                        o_cmd.cnt_inc  = 1'b1;
                    end
                end
                OP_RM_HEAD: begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.head_inc = 1'b1;
                        o_cmd.cnt_dec  = 1'b1;
                    end
                end
                OP_RM_TAIL: begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end
                OP_RD_HEAD: begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.addr_sel = ASEL_HEAD;
                        o_cmd.rd_hit   = 1'b1;
                    end
                end
                OP_RD_TAIL: begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.addr_sel = ASEL_TAIL;
                        o_cmd.rd_hit   = 1'b1;
                    end
                end
                OP_RD_INDEX: begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else if (i_stat.pos_oob) begin
                        o_cmd.status = ST_RANGE;
                    end else begin
                        o_cmd.addr_sel = ASEL_INDEX;
                        o_cmd.rd_hit   = 1'b1;
                    end
                end
                default: begin
                    o_cmd.status = ST_OK;
                end
            endcase
        end
    end

    // An accepted request is executed in the very next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_ready && i_s_valid) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // Execution always leads to a pending result.
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_m_valid)
        else $error("execution did not produce a result");

    // Input and output are never open in the same cycle.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_ready && o_m_valid))
        else $error("ready and result valid together");

endmodule

`default_nettype wire

>>> sv/bpd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bpd_datapath
    import bpd_pkg::*;
#(
    parameter int CAPACITY = BPD_CAPACITY
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [IN_W-1:0]   i_s_tdata,
    output logic [OUT_W-1:0]  o_m_tdata,
    input  t_cmd              i_cmd,
    output t_stat             o_stat
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;

    // Latched request.
    logic [OP_W-1:0]    r_op;
    logic [ENTRY_W-1:0] r_entry;
    logic [BYTE_W-1:0]  r_pos;

    // List state.
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;

    // Result registers.
    logic [STATUS_W-1:0] r_status;
    logic                r_hit;
    logic [ENTRY_W-1:0]  r_rd_data;

    // Entry storage.
    logic [ENTRY_W-1:0] r_mem [CAPACITY];

    logic [PTR_W-1:0] head_prev;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] offset;
    logic [SUM_W-1:0] slot_sum;
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] addr;

    // Capture a request when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_s_tdata[OP_W-1:0];
            r_entry <= i_s_tdata[OP_W +: ENTRY_W];
            r_pos   <= i_s_tdata[OP_W+ENTRY_W +: BYTE_W];
        end
    end

    // Flags for the controller's decode.
    assign o_stat.op      = r_op;
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count == CNT_W'(CAPACITY));
    assign o_stat.pos_oob = (CMP_W'(r_pos) >= CMP_W'(r_count));

    // Neighbors of the head slot, wrapping around the buffer.
    assign head_prev = (r_head == '0) ? PTR_W'(CAPACITY - 1) : r_head - 1'b1;
    assign head_next = (r_head == PTR_W'(CAPACITY - 1)) ? '0 : r_head + 1'b1;

    // Offset from the head for the slot being addressed.
    always_comb begin
        unique case (i_cmd.addr_sel)
            ASEL_TAIL_NEW: offset = r_count;
            ASEL_TAIL:     offset = r_count - 1'b1;
            ASEL_INDEX:    offset = CNT_W'(r_pos);
            default:       offset = '0;
        endcase
    end

    // Head plus offset, reduced once by the capacity.
    assign slot_sum = SUM_W'(r_head) + SUM_W'(offset);
    assign slot     = (slot_sum >= SUM_W'(CAPACITY)) ?
                      PTR_W'(slot_sum - SUM_W'(CAPACITY)) : PTR_W'(slot_sum);
    assign addr     = (i_cmd.addr_sel == ASEL_HEAD_PREV) ? head_prev : slot;

    // Single-port storage access: write on inserts, registered read on every access.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (i_cmd.wr_en) begin
                r_mem[addr] <= r_entry;
            end
            r_rd_data <= r_mem[addr];
        end
    end

    // Head pointer and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (i_cmd.head_dec) begin
                r_head <= head_prev;
            end else if (i_cmd.head_inc) begin
                r_head <= head_next;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Result status and read flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= i_cmd.status;
            r_hit    <= i_cmd.rd_hit;
        end
    end

    // Result word: status, entry read or zeros, occupancy, zero padding.
    assign o_m_tdata = {
        {(OUT_W - STATUS_W - ENTRY_W - OCC_W){1'b0}},
        OCC_W'(r_count),
        (r_hit ? r_rd_data : {ENTRY_W{1'b0}}),
        r_status
    };

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A read is never issued against an empty list.
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_cmd.rd_hit) |-> !o_stat.empty)
        else $error("read issued on empty list");

    // List state changes only while a request executes.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_count) && $stable(r_head)))
        else $error("list state changed outside execution");

endmodule

`default_nettype wire

>>> test/deque_result_checker.sv
`timescale 1ns / 1ps

module deque_result_checker
    import bpd_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_req_valid,
    input  wire             i_req_ready,
    input  wire [IN_W-1:0]  i_req_data,
    input  wire             i_res_valid,
    input  wire             i_res_ready,
    input  wire [OUT_W-1:0] i_res_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_requests,
    output int              o_results,
    output int              o_peak_occupancy,
    output logic [3:0]      o_status_seen
);

    // One result as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   symbol;
        logic [BYTE_W-1:0]   x;
        logic [BYTE_W-1:0]   y;
        logic [OCC_W-1:0]    occupancy;
    } t_result;

    // Mirror of the list: circular store, head slot and number of entries held.
    logic [ENTRY_W-1:0] entry_mem [BPD_CAPACITY];
    int unsigned        head_slot = 0;
    int unsigned        held = 0;
    t_result            pending_results [$];
    int                 fails = 0;
    int                 requests = 0;
    int                 results = 0;
    int                 peak = 0;
    logic [3:0]         seen = '0;
    t_result            want;
    t_result            got;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_requests       = 0;
        o_results        = 0;
        o_peak_occupancy = 0;
        o_status_seen    = '0;
    end

    // Applies one request to the mirror and works out the result it yields.
    task automatic apply_deque_op(input logic [IN_W-1:0] req, output t_result res);
        logic [OP_W-1:0]    op;
        logic [ENTRY_W-1:0] entry;
        logic [BYTE_W-1:0]  pos;
        logic [ENTRY_W-1:0] rd;
        op    = req[2:0];
        entry = req[26:3];
        pos   = req[34:27];
        rd    = '0;
        res.status = ST_OK;
        case (op)
            OP_INS_HEAD: begin
                if (held >= BPD_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    head_slot = (head_slot + BPD_CAPACITY - 1) % BPD_CAPACITY;
                    entry_mem[head_slot] = entry;
                    held++;
                end
            end
            OP_INS_TAIL: begin
                if (held >= BPD_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    entry_mem[(head_slot + held) % BPD_CAPACITY] = entry;
                    held++;
                end
            end
            OP_RM_HEAD: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    head_slot = (head_slot + 1) % BPD_CAPACITY;
                    held--;
                end
            end
            OP_RM_TAIL: begin
                if (held == 0) res.status = ST_EMPTY;
                else held--;
            end
            OP_RD_HEAD: begin
                if (held == 0) res.status = ST_EMPTY;
                else rd = entry_mem[head_slot];
            end
            OP_RD_TAIL: begin
                if (held == 0) res.status = ST_EMPTY;
                else rd = entry_mem[(head_slot + held - 1) % BPD_CAPACITY];
            end
            OP_RD_INDEX: begin
                if (held == 0) res.status = ST_EMPTY;
                else if (pos >= held) res.status = ST_RANGE;
                else rd = entry_mem[(head_slot + pos) % BPD_CAPACITY];
            end
            default: begin
                // The unused operation code leaves everything as it is.
            end
        endcase
        res.symbol    = rd[7:0];
        res.x         = rd[15:8];
        res.y         = rd[23:16];
        res.occupancy = OCC_W'(held);
    endtask

    // Reports one field that differs from its expected value.
    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    // Predict on every accepted request and compare every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot = 0;
            held      = 0;
            pending_results.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                apply_deque_op(i_req_data, want);
                pending_results.push_back(want);
                requests++;
                seen[want.status] = 1'b1;
                if (held > peak) peak = held;
            end
            if (i_res_valid && i_res_ready) begin
                got.status    = i_res_data[1:0];
                got.symbol    = i_res_data[9:2];
                got.x         = i_res_data[17:10];
                got.y         = i_res_data[25:18];
                got.occupancy = i_res_data[34:26];
                results++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, got);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("symbol", want.symbol, got.symbol);
                    check_field("x", want.x, got.x);
                    check_field("y", want.y, got.y);
                    check_field("occupancy", want.occupancy, got.occupancy);
                end
            end
        end
        o_fail_count     <= fails;
        o_pending        <= pending_results.size();
        o_requests       <= requests;
        o_results        <= results;
        o_peak_occupancy <= peak;
        o_status_seen    <= seen;
    end

endmodule

>>> test/bounded_position_deque_tb.sv
`timescale 1ns / 1ps

module bounded_position_deque_tb
    import bpd_pkg::*;
();

    localparam int N_RANDOM       = 480;
    localparam int CALM_TAIL      = 100;
    localparam int PAUSE_AT       = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    // The one operation code the block leaves unused.
    localparam logic [OP_W-1:0] OP_NOP = 3'd7;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tready = 1'b0;
    wire              s_axis_tready;
    wire              m_axis_tvalid;
    wire [OUT_W-1:0]  m_axis_tdata;

    logic             idling = 1'b1;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int unsigned      fill = 0;

    int               fail_count;
    int               pending;
    int               requests;
    int               results;
    int               peak_occupancy;
    logic [3:0]       status_seen;

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    bounded_position_deque i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    deque_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (s_axis_tvalid),
        .i_req_ready      (s_axis_tready),
        .i_req_data       (s_axis_tdata),
        .i_res_valid      (m_axis_tvalid),
        .i_res_ready      (m_axis_tready),
        .i_res_data       (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_requests       (requests),
        .o_results        (results),
        .o_peak_occupancy (peak_occupancy),
        .o_status_seen    (status_seen)
    );

    // Receiver back-pressure in random bursts that start only while idling is set.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random byte with the extremes favored.
    function automatic logic [7:0] rand_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Position for a read by index: mostly in range, with the edges of the range.
    function automatic logic [7:0] pick_position();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (fill == 0 || roll >= 8) return 8'($urandom_range(0, 255));
        if (roll == 6) return 8'(fill - 1);
        if (roll == 7) return (fill > 255) ? 8'hFF : 8'(fill);
        return 8'($urandom_range(0, fill - 1));
    endfunction

    // Sends one request, tracks the list size for steering, then maybe idles.
    task automatic issue(input logic [OP_W-1:0] op, input logic [7:0] sym,
                         input logic [7:0] x, input logic [7:0] y,
                         input logic [7:0] pos);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 35){1'b0}}, pos, y, x, sym, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (op)
            OP_INS_HEAD, OP_INS_TAIL: if (fill < BPD_CAPACITY) fill++;
            OP_RM_HEAD, OP_RM_TAIL:   if (fill > 0) fill--;
            default: ;
        endcase
        if (idling && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Lowers valid and waits until every expected result has arrived.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned     roll;
        logic [OP_W-1:0] op;
        bit              grow;
        int              dwell;
        grow  = 1'b1;
        dwell = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every removal and read on the empty list, plus the unused code.
        issue(OP_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_NOP, 8'h00, 8'h00, 8'h00, 8'h00);

        // Inserts at both ends with extreme field values; head insert wraps slot zero.
        issue(OP_INS_TAIL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        issue(OP_INS_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_INS_TAIL, 8'hA5, 8'h5A, 8'hC3, 8'h00);
        issue(OP_INS_HEAD, 8'h3C, 8'h81, 8'h7E, 8'hFF);

        // Reads at both ends, by index in and out of range, and the unused code.
        issue(OP_RD_HEAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        issue(OP_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h03);
        issue(OP_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h04);
        issue(OP_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'hFF);
        issue(OP_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // Drain from both ends back to empty, then once more past empty.
        issue(OP_RM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h01);
        issue(OP_RM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
        issue(OP_RM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);

        // Random part: grow toward full, linger there, then shrink toward empty, and so on.
        for (int i = 0; i < N_RANDOM; i++) begin
            idling <= !((i >= 250 && i < 320) || i >= N_RANDOM - CALM_TAIL);
            if (i == PAUSE_AT) wait_all_results();

            if (grow && fill == BPD_CAPACITY) begin
                dwell++;
                if (dwell > 8) begin
                    grow  = 1'b0;
                    dwell = 0;
                end
            end else if (!grow && fill == 0) begin
                dwell++;
                if (dwell > 5) begin
                    grow  = 1'b1;
                    dwell = 0;
                end
            end

            roll = $urandom_range(0, 99);
            if (roll < 90 && grow || roll >= 90 && roll < 93 && !grow) begin
                op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
            end else if (roll < 93) begin
                op = $urandom_range(0, 1) ? OP_RM_HEAD : OP_RM_TAIL;
            end else if (roll < 99) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_RD_HEAD;
                    1:       op = OP_RD_TAIL;
                    default: op = OP_RD_INDEX;
                endcase
            end else begin
                op = OP_NOP;
            end
            issue(op, rand_byte(), rand_byte(), rand_byte(), pick_position());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d results, peak occupancy %0d of %0d.",
                 requests, results, peak_occupancy, BPD_CAPACITY);
        $display("Status codes seen, one bit per code from ok up: %b.", status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/bpd_pkg.sv
sv/bpd_ctrl.sv
sv/bpd_datapath.sv
sv/bounded_position_deque.sv
test/deque_result_checker.sv
test/bounded_position_deque_tb.sv
